>>> sv/stpc_pkg.sv
package stpc_pkg;

	localparam int RAW_W = 10;
	localparam int PCT_W = 7;
	localparam int STATE_W = 28;
	localparam int OUT_W = 11;
	localparam int DEN_W = RAW_W + 1;
	localparam int PROD_W = 18;
	localparam int TDATA_W = 16;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam int AVG_PERIOD_DEF = 10;
	localparam int FRAC_BITS_DEF = 8;

	localparam logic [RAW_W-1:0] LOW_RAW_RST = RAW_W'(100);
	localparam logic [PCT_W-1:0] LOW_PCT_RST = PCT_W'(40);
	localparam logic [RAW_W-1:0] HIGH_RAW_RST = RAW_W'(800);
	localparam logic [PCT_W-1:0] HIGH_PCT_RST = PCT_W'(100);

	typedef enum logic [1:0] {
		REG_LOW_RAW,
		REG_LOW_PCT,
		REG_HIGH_RAW,
		REG_HIGH_PCT
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_CAL,
		ST_DIV_CAL,
		ST_WAIT_CAL,
		ST_STORE_V,
		ST_MUL_AVG,
		ST_SUM_AVG,
		ST_RCP_AVG,
		ST_STORE_AVG,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic mul_cal;
		logic div_start;
		logic store_v;
		logic mul_avg;
		logic sum_avg;
		logic rcp_avg;
		logic store_avg;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic seeded;
	} sts_t;

endpackage

>>> sv/stpc_div.sv
module stpc_div #(
	parameter int NUM_W = 34
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [NUM_W:0]            num,
	input  logic signed [stpc_pkg::DEN_W:0]  den,
	output logic signed [NUM_W:0]            quot,
	output logic                             done
);

	localparam int DW = stpc_pkg::DEN_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic             neg_q;
	logic [NUM_W-1:0] quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;

	logic signed [NUM_W:0] num_mag;
	logic signed [DW:0]    den_mag;
	logic [DW:0]           sh;
	logic [DW:0]           trial;
	logic                  ge;
	logic [DW-1:0]         rem_nx;
	logic [NUM_W-1:0]      quo_nx;

	assign num_mag = num[NUM_W] ? -num : num;
	assign den_mag = den[DW] ? -den : den;
	assign sh = {rem_q, quo_q[NUM_W-1]};
	assign ge = sh >= {1'b0, den_q};
	assign trial = sh - {1'b0, den_q};
	assign rem_nx = ge ? trial[DW-1:0] : sh[DW-1:0];
	assign quo_nx = {quo_q[NUM_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num_mag[NUM_W-1:0];
			rem_q <= '0;
			den_q <= den_mag[DW-1:0];
			neg_q <= num[NUM_W] ^ den[DW];
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign done = done_q;

endmodule

>>> sv/stpc_dp.sv
module stpc_dp #(
	parameter int AVG_PERIOD = stpc_pkg::AVG_PERIOD_DEF,
	parameter int FRAC_BITS = stpc_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  stpc_pkg::cmd_t                   cmd,
	output stpc_pkg::sts_t                   sts,
	input  logic [stpc_pkg::RAW_W-1:0]       adc_sample,
	input  logic [stpc_pkg::RAW_W-1:0]       ref_low_raw,
	input  logic [stpc_pkg::PCT_W-1:0]       ref_low_percent,
	input  logic [stpc_pkg::RAW_W-1:0]       ref_high_raw,
	input  logic [stpc_pkg::PCT_W-1:0]       ref_high_percent,
	output logic signed [stpc_pkg::OUT_W-1:0] humidity_percent
);

	localparam int RW = stpc_pkg::RAW_W;
	localparam int PCW = stpc_pkg::PCT_W;
	localparam int SW = stpc_pkg::STATE_W;
	localparam int OW = stpc_pkg::OUT_W;
	localparam int DW = stpc_pkg::DEN_W;
	localparam int PRW = stpc_pkg::PROD_W;
	localparam int PW = $clog2(AVG_PERIOD + 1);
	localparam int CAL_W = PRW - 1 + FRAC_BITS;
	localparam int AVG_W = SW + PW;
	localparam int NUM_W = ((CAL_W > AVG_W) ? CAL_W : AVG_W) + 1;
	localparam int NM = AVG_W - 1;
	localparam int RCP_S = NM + $clog2(AVG_PERIOD);
	localparam longint RCP_L =
		((longint'(1) << RCP_S) + longint'(AVG_PERIOD - 1)) / longint'(AVG_PERIOD);
	localparam logic [NM:0] RCP = (NM + 1)'(RCP_L);
	localparam logic [PW-1:0] PM1 = PW'(AVG_PERIOD - 1);
	localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [OW-1:0] OMAX = {1'b0, {(OW-1){1'b1}}};
	localparam logic signed [OW-1:0] OMIN = {1'b1, {(OW-1){1'b0}}};

	function automatic logic signed [SW-1:0] sat_state(input logic signed [NUM_W+1:0] a);
		logic [NUM_W+2-SW:0] hi;
		logic signed [SW-1:0] r;
		hi = a[NUM_W+1:SW-1];
		if (hi == '0 || hi == '1) begin
			r = a[SW-1:0];
		end else if (a[NUM_W+1]) begin
			r = SMIN;
		end else begin
			r = SMAX;
		end
		return r;
	endfunction

	logic [RW-1:0]          x_q;
	logic signed [NUM_W:0]  prod_q;
	logic signed [SW-1:0]   v_q;
	logic signed [SW-1:0]   avg_q;
	logic                   seeded_q;
	logic signed [OW-1:0]   out_q;
	logic [NM-1:0]          sum_mag_q;
	logic                   sum_neg_q;
	logic [2*NM:0]          rcp_q;

	logic signed [RW:0]       dx;
	logic signed [PCW:0]      dy;
	logic signed [RW:0]       den;
	logic                     den_zero;
	logic signed [RW+PCW+1:0] cal_prod;
	logic signed [NUM_W:0]    cal_ext;
	logic signed [SW+PW:0]    avg_prod;
	logic signed [NUM_W:0]    v_ext;
	logic signed [NUM_W:0]    y1_fix;
	logic signed [NUM_W:0]    div_num;
	logic signed [DW:0]       div_den;
	logic signed [NUM_W:0]    quot;
	logic                     div_done;
	logic signed [NUM_W+1:0]  cal_sum;
	logic signed [SW-1:0]     cal_v;
	logic signed [NUM_W:0]    avg_sum;
	logic signed [NUM_W:0]    avg_mag;
	logic [2*NM-RCP_S:0]      rcp_quo;
	logic signed [NUM_W+1:0]  rcp_ext;
	logic signed [NUM_W+1:0]  avg_ext;
	logic signed [SW-1:0]     avg_new;
	logic signed [SW-1:0]     avg_int;
	logic [SW-OW:0]           avg_hi;
	logic signed [OW-1:0]     pct;

	assign dx = $signed({1'b0, x_q}) - $signed({1'b0, ref_low_raw});
	assign dy = $signed({1'b0, ref_high_percent}) - $signed({1'b0, ref_low_percent});
	assign den = $signed({1'b0, ref_high_raw}) - $signed({1'b0, ref_low_raw});
	assign den_zero = den == '0;
	assign cal_prod = dx * dy;
	assign cal_ext = {{(NUM_W+1-PRW){cal_prod[PRW-1]}}, cal_prod[PRW-1:0]};
	assign avg_prod = avg_q * $signed({1'b0, PM1});
	assign v_ext = {{(NUM_W+1-SW){v_q[SW-1]}}, v_q};
	assign y1_fix = $signed({{(NUM_W+1-PCW){1'b0}}, ref_low_percent}) <<< FRAC_BITS;

	assign div_num = prod_q;
	assign div_den = {den[RW], den};

	stpc_div #(
		.NUM_W(NUM_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(div_num),
		.den(div_den),
		.quot(quot),
		.done(div_done)
	);

	assign cal_sum = {quot[NUM_W], quot} + {y1_fix[NUM_W], y1_fix};
	assign cal_v = den_zero ? '0 : sat_state(cal_sum);

	// divide by the period with a rounded-up reciprocal; exact for any magnitude in NM bits
	assign avg_sum = prod_q + v_ext;
	assign avg_mag = avg_sum[NUM_W] ? -avg_sum : avg_sum;
	assign rcp_quo = rcp_q[2*NM:RCP_S];
	assign rcp_ext = $signed({{(NUM_W+1-(2*NM-RCP_S)){1'b0}}, rcp_quo});
	assign avg_ext = sum_neg_q ? -rcp_ext : rcp_ext;
	assign avg_new = sat_state(avg_ext);

	// truncate toward zero: bump negative values that had fraction bits
	assign avg_int = (avg_q >>> FRAC_BITS)
		+ $signed(SW'(avg_q[SW-1] && (avg_q[FRAC_BITS-1:0] != '0)));
	assign avg_hi = avg_int[SW-1:OW-1];
	always_comb begin
		if (avg_hi == '0 || avg_hi == '1) begin
			pct = avg_int[OW-1:0];
		end else if (avg_int[SW-1]) begin
			pct = OMIN;
		end else begin
			pct = OMAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			avg_q <= '0;
		end else if (cmd.store_v && !seeded_q) begin
			seeded_q <= 1'b1;
			avg_q <= cal_v;
		end else if (cmd.store_avg) begin
			avg_q <= avg_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q <= adc_sample;
		end
		if (cmd.mul_cal) begin
			prod_q <= cal_ext <<< FRAC_BITS;
		end else if (cmd.mul_avg) begin
			prod_q <= {{(NUM_W-SW-PW){avg_prod[SW+PW]}}, avg_prod};
		end
		if (cmd.store_v) begin
			v_q <= cal_v;
		end
		if (cmd.sum_avg) begin
			sum_mag_q <= avg_mag[NM-1:0];
			sum_neg_q <= avg_sum[NUM_W];
		end
		if (cmd.rcp_avg) begin
			rcp_q <= sum_mag_q * RCP;
		end
		if (cmd.load_out) begin
			out_q <= pct;
		end
	end

	assign sts.div_done = div_done;
	assign sts.seeded = seeded_q;
	assign humidity_percent = out_q;

endmodule

>>> sv/stpc_ctrl.sv
module stpc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  stpc_pkg::sts_t sts,
	output stpc_pkg::cmd_t cmd
);

	stpc_pkg::state_t state_q;
	stpc_pkg::state_t state_nx;
	logic             m_tvalid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			stpc_pkg::ST_IDLE: begin
				if (s_tvalid) state_nx = stpc_pkg::ST_MUL_CAL;
			end
			stpc_pkg::ST_MUL_CAL: state_nx = stpc_pkg::ST_DIV_CAL;
			stpc_pkg::ST_DIV_CAL: state_nx = stpc_pkg::ST_WAIT_CAL;
			stpc_pkg::ST_WAIT_CAL: begin
				if (sts.div_done) state_nx = stpc_pkg::ST_STORE_V;
			end
			stpc_pkg::ST_STORE_V: begin
				// the first sample only seeds the average
				state_nx = sts.seeded ? stpc_pkg::ST_MUL_AVG : stpc_pkg::ST_OUT;
			end
			stpc_pkg::ST_MUL_AVG: state_nx = stpc_pkg::ST_SUM_AVG;
			stpc_pkg::ST_SUM_AVG: state_nx = stpc_pkg::ST_RCP_AVG;
			stpc_pkg::ST_RCP_AVG: state_nx = stpc_pkg::ST_STORE_AVG;
			stpc_pkg::ST_STORE_AVG: state_nx = stpc_pkg::ST_OUT;
			stpc_pkg::ST_OUT: begin
				if (!m_tvalid_q || m_tready) state_nx = stpc_pkg::ST_IDLE;
			end
			default: state_nx = stpc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			stpc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load_in = s_tvalid;
			end
			stpc_pkg::ST_MUL_CAL: cmd.mul_cal = 1'b1;
			stpc_pkg::ST_DIV_CAL: cmd.div_start = 1'b1;
			stpc_pkg::ST_STORE_V: cmd.store_v = 1'b1;
			stpc_pkg::ST_MUL_AVG: cmd.mul_avg = 1'b1;
			stpc_pkg::ST_SUM_AVG: cmd.sum_avg = 1'b1;
			stpc_pkg::ST_RCP_AVG: cmd.rcp_avg = 1'b1;
			stpc_pkg::ST_STORE_AVG: cmd.store_avg = 1'b1;
			stpc_pkg::ST_OUT: cmd.load_out = !m_tvalid_q || m_tready;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stpc_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

>>> sv/sensor_two_point_calibration_ema.sv
// Moisture sensor calibration with smoothing.
// Slave stream: one 10-bit converter sample per request on s_tdata.
// Master stream: one 11-bit signed smoothed percent per request on m_tdata.
// Each sample is mapped through the line set by the two reference points
// (APB registers at 0x0, 0x4, 0x8, 0xC), then folded into a moving average.
// A sample is multiplied, divided and stored; every sample but the first
// after reset, which only seeds the average, then runs the average update.
// The calibration slope goes through a restoring divider at one cycle per
// quotient bit (33 bits by default); the average update divides by the
// period with a reciprocal multiply: multiply, sum, reciprocal, store.
// Throughput: one sample at a time; s_tready is high only between samples,
// so a new sample is taken only once the last result is in the output register.
// A finished result sits in the output register while the next sample is
// taken; if the receiver still holds m_tready low when that one is done, the
// block waits with it until the register frees up.
// Reset: reference points return to (100, 40) and (800, 100), the average
// is cleared and unseeded, and the output stream goes empty.
// Write the registers only while no sample is in flight.
module sensor_two_point_calibration_ema #(
	parameter int AVG_PERIOD = stpc_pkg::AVG_PERIOD_DEF,
	parameter int FRAC_BITS = stpc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [stpc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [stpc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [stpc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [stpc_pkg::TDATA_W-1:0]        s_tdata,  // [9:0] adc_sample
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [stpc_pkg::TDATA_W-1:0]        m_tdata   // [10:0] humidity_percent
);

	localparam int RW = stpc_pkg::RAW_W;
	localparam int PCW = stpc_pkg::PCT_W;
	localparam int OW = stpc_pkg::OUT_W;
	localparam int DATA_W = stpc_pkg::APB_DATA_W;

	logic [RW-1:0]  low_raw_q;
	logic [PCW-1:0] low_pct_q;
	logic [RW-1:0]  high_raw_q;
	logic [PCW-1:0] high_pct_q;

	stpc_pkg::reg_idx_t reg_idx;
	logic               wr_en;

	stpc_pkg::cmd_t        cmd;
	stpc_pkg::sts_t        sts;
	logic signed [OW-1:0]  humidity_percent;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = stpc_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_raw_q <= stpc_pkg::LOW_RAW_RST;
			low_pct_q <= stpc_pkg::LOW_PCT_RST;
			high_raw_q <= stpc_pkg::HIGH_RAW_RST;
			high_pct_q <= stpc_pkg::HIGH_PCT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				stpc_pkg::REG_LOW_RAW: low_raw_q <= pwdata[RW-1:0];
				stpc_pkg::REG_LOW_PCT: low_pct_q <= pwdata[PCW-1:0];
				stpc_pkg::REG_HIGH_RAW: high_raw_q <= pwdata[RW-1:0];
				stpc_pkg::REG_HIGH_PCT: high_pct_q <= pwdata[PCW-1:0];
				default: low_raw_q <= low_raw_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			stpc_pkg::REG_LOW_RAW: prdata = DATA_W'(low_raw_q);
			stpc_pkg::REG_LOW_PCT: prdata = DATA_W'(low_pct_q);
			stpc_pkg::REG_HIGH_RAW: prdata = DATA_W'(high_raw_q);
			stpc_pkg::REG_HIGH_PCT: prdata = DATA_W'(high_pct_q);
			default: prdata = '0;
		endcase
	end

	stpc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts(sts),
		.cmd(cmd)
	);

	stpc_dp #(
		.AVG_PERIOD(AVG_PERIOD),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.adc_sample(s_tdata[RW-1:0]),
		.ref_low_raw(low_raw_q),
		.ref_low_percent(low_pct_q),
		.ref_high_raw(high_raw_q),
		.ref_high_percent(high_pct_q),
		.humidity_percent(humidity_percent)
	);

	assign m_tdata = {{(stpc_pkg::TDATA_W-OW){1'b0}}, humidity_percent};

endmodule
